### hdl/cmvc_pkg.sv
// ----------------------------------------------------------------------------
// cmvc_pkg
// Shared types and constants for the center-of-mass velocity contact block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmvc_pkg;

  localparam int unsigned DATA_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MIDX_W    = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_ACC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP   = 2'd1;

  localparam logic [DATA_W-1:0] INV_STEP_RESET = 24'd4096;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 24'sh800000;

  typedef struct packed {
    logic [DATA_W-1:0]        mass;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] acc_x;
    logic signed [DATA_W-1:0] acc_y;
    logic signed [DATA_W-1:0] acc_z;
    logic                     last_material;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic signed [DATA_W-1:0] new_vel_z;
    logic signed [DATA_W-1:0] new_acc_x;
    logic signed [DATA_W-1:0] new_acc_y;
    logic signed [DATA_W-1:0] new_acc_z;
    logic [MIDX_W-1:0]        material_index;
    logic                     last_result;
    logic                     zero_mass;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic       in_ready;
    logic       mac;
    logic       div_chk;
    logic       div_step;
    logic       div_fin;
    logic       mul;
    logic       add;
    logic       out_load;
    logic       k_inc;
    logic       clr;
    logic [1:0] comp;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic full;
    logic last;
    logic zm;
    logic sat;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/cmvc_item_if.sv
// ----------------------------------------------------------------------------
// cmvc_item_if
// Input item channel: valid/ready plus one material item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmvc_item_if import cmvc_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/cmvc_result_if.sv
// ----------------------------------------------------------------------------
// cmvc_result_if
// Result channel: valid/ready plus one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmvc_result_if import cmvc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/cmvc_cfg_if.sv
// ----------------------------------------------------------------------------
// cmvc_cfg_if
// Configuration write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmvc_cfg_if import cmvc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/cmvc_ram.sv
// ----------------------------------------------------------------------------
// cmvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/cmvc_dp.sv
// ----------------------------------------------------------------------------
// cmvc_dp
// Datapath: item buffer, momentum/mass sums, bit-serial divider,
// acceleration correction and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmvc_dp import cmvc_pkg::*; #(
  parameter int unsigned MAX_MATERIALS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  cmvc_item_if.sink     item_i,
  cmvc_result_if.source result_o,
  cmvc_cfg_if.sink      cfg_i,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam int unsigned LOGM  = $clog2(MAX_MATERIALS);
  localparam int unsigned IW    = (MAX_MATERIALS > 1) ? LOGM : 1;
  localparam int unsigned CW    = $clog2(MAX_MATERIALS + 1);
  localparam int unsigned MS_W  = DATA_W + LOGM;
  localparam int unsigned MOM_W = 2 * DATA_W + LOGM;
  localparam int unsigned ROW_W = 6 * DATA_W;
  localparam int unsigned PR_W  = 2 * DATA_W + 2;
  localparam int unsigned AC_W  = 38;

  // Configuration
  logic              adj_q;
  logic [DATA_W-1:0] its_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= 1'b0;
      its_q <= INV_STEP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ADJUST_ACC: adj_q <= cfg_i.data[0];
        CFG_INV_STEP:   its_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input transfer
  logic accept;
  logic [CW-1:0] cnt_q;
  logic full;

  assign item_i.ready = cmd_i.in_ready;
  assign accept       = item_i.valid && cmd_i.in_ready;
  assign full         = (cnt_q == CW'(MAX_MATERIALS));

  // Material buffer: one row per material
  logic [IW-1:0]    k_q;
  logic [ROW_W-1:0] row_wr, row_rd;

  assign row_wr = {item_i.data.acc_z, item_i.data.acc_y, item_i.data.acc_x,
                   item_i.data.vel_z, item_i.data.vel_y, item_i.data.vel_x};

  cmvc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_MATERIALS), .AW(IW)) u_buf (
    .clk_i   (clk_i),
    .we_i    (accept && !full),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (row_wr),
    .raddr_i (k_q),
    .rdata_o (row_rd)
  );

  // Sums and count
  logic [MS_W-1:0]         msum_q;
  logic signed [MOM_W-1:0] mom_q [3];
  logic [DATA_W-1:0]       m_q;
  logic signed [DATA_W-1:0] v_q [3];
  logic                    last_q;
  logic signed [DATA_W:0]  mterm;
  logic signed [2*DATA_W:0] mprod;

  assign mterm = $signed({1'b0, m_q});
  assign mprod = v_q[cmd_i.comp] * mterm;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q    <= item_i.data.mass;
      v_q[0] <= item_i.data.vel_x;
      v_q[1] <= item_i.data.vel_y;
      v_q[2] <= item_i.data.vel_z;
      last_q <= item_i.data.last_material;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      msum_q <= '0;
      mom_q[0] <= '0;
      mom_q[1] <= '0;
      mom_q[2] <= '0;
    end else if (cmd_i.clr) begin
      cnt_q  <= '0;
      msum_q <= '0;
      mom_q[0] <= '0;
      mom_q[1] <= '0;
      mom_q[2] <= '0;
    end else begin
      if (accept && !full) begin
        cnt_q  <= cnt_q + CW'(1);
        msum_q <= msum_q + MS_W'(item_i.data.mass);
      end
      if (cmd_i.mac) begin
        mom_q[cmd_i.comp] <= mom_q[cmd_i.comp] + MOM_W'(mprod);
      end
    end
  end

  // Divider: magnitude restoring division, one quotient bit a cycle
  logic signed [MOM_W-1:0] msel;
  logic [MOM_W-1:0]        nabs;
  logic                    sat, zm;
  logic [MS_W-1:0]         rem_q;
  logic [DATA_W-1:0]       nsh_q, q_q;
  logic                    neg_q;
  logic [MS_W:0]           trial;
  logic                    ge;
  logic signed [DATA_W-1:0] vcm_q [3];

  assign zm    = (msum_q == '0);
  assign msel  = mom_q[cmd_i.comp];
  assign nabs  = msel[MOM_W-1] ? MOM_W'(-msel) : MOM_W'(msel);
  assign sat   = (nabs >= {msum_q, {DATA_W{1'b0}}});
  assign trial = {rem_q, nsh_q[DATA_W-1]};
  assign ge    = (trial >= {1'b0, msum_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_chk) begin
      if (zm) begin
        vcm_q[0] <= '0;
        vcm_q[1] <= '0;
        vcm_q[2] <= '0;
      end else if (sat) begin
        vcm_q[cmd_i.comp] <= msel[MOM_W-1] ? SAT_MIN : SAT_MAX;
      end
      rem_q <= nabs[MOM_W-1:DATA_W];
      nsh_q <= nabs[DATA_W-1:0];
      neg_q <= msel[MOM_W-1];
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? MS_W'(trial - {1'b0, msum_q}) : trial[MS_W-1:0];
      nsh_q <= {nsh_q[DATA_W-2:0], 1'b0};
      q_q   <= {q_q[DATA_W-2:0], ge};
    end else if (cmd_i.div_fin) begin
      priority if (!neg_q && (q_q > DATA_W'(SAT_MAX))) begin
        vcm_q[cmd_i.comp] <= SAT_MAX;
      end else if (neg_q && (q_q > DATA_W'(SAT_MIN))) begin
        vcm_q[cmd_i.comp] <= SAT_MIN;
      end else if (neg_q) begin
        vcm_q[cmd_i.comp] <= -$signed(q_q);
      end else begin
        vcm_q[cmd_i.comp] <= $signed(q_q);
      end
    end
  end

  // Acceleration correction, one component a pass
  logic signed [DATA_W-1:0] rv, ra;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W:0]   itsx;
  logic signed [2*DATA_W:0] cprod;
  logic signed [PR_W-1:0]   prod_q;
  logic signed [PR_W:0]     rsum;
  logic signed [PR_W:0]     rsh;
  logic signed [AC_W-1:0]   asum;
  logic signed [DATA_W-1:0] asat;
  logic signed [DATA_W-1:0] na_q [3];

  assign rv    = row_rd[cmd_i.comp * DATA_W +: DATA_W];
  assign ra    = row_rd[(cmd_i.comp + 2'd3) * DATA_W +: DATA_W];
  assign diff  = {vcm_q[cmd_i.comp][DATA_W-1], vcm_q[cmd_i.comp]} - {rv[DATA_W-1], rv};
  assign itsx  = $signed({1'b0, its_q});
  assign cprod = diff * itsx;
  assign rsum  = {prod_q[PR_W-1], prod_q} + (PR_W+1)'(2048);
  assign rsh   = rsum >>> 12;
  assign asum  = AC_W'(ra) + rsh[AC_W-1:0];

  always_comb begin
    priority if (asum > AC_W'(SAT_MAX)) begin
      asat = SAT_MAX;
    end else if (asum < AC_W'(SAT_MIN)) begin
      asat = SAT_MIN;
    end else begin
      asat = asum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PR_W'(cprod);
    end
    if (cmd_i.add) begin
      na_q[cmd_i.comp] <= (adj_q && !zm) ? asat : ra;
    end
  end

  // Emission index
  logic k_last;

  assign k_last = ((CW'(k_q) + CW'(1)) == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + IW'(1);
    end
  end

  // Output register
  logic    ovalid_q;
  result_t odata_q;
  logic    out_free;

  assign out_free = !ovalid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (result_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      odata_q.new_vel_x      <= vcm_q[0];
      odata_q.new_vel_y      <= vcm_q[1];
      odata_q.new_vel_z      <= vcm_q[2];
      odata_q.new_acc_x      <= na_q[0];
      odata_q.new_acc_y      <= na_q[1];
      odata_q.new_acc_z      <= na_q[2];
      odata_q.material_index <= MIDX_W'(k_q);
      odata_q.last_result    <= k_last;
      odata_q.zero_mass      <= zm;
    end
  end

  assign result_o.valid = ovalid_q;
  assign result_o.data  = odata_q;

  // Status
  assign sts_o.in_valid = item_i.valid;
  assign sts_o.in_last  = item_i.data.last_material;
  assign sts_o.full     = full;
  assign sts_o.last     = last_q;
  assign sts_o.zm       = zm;
  assign sts_o.sat      = sat;
  assign sts_o.k_last   = k_last;
  assign sts_o.out_free = out_free;

endmodule

### hdl/cmvc_ctrl.sv
// ----------------------------------------------------------------------------
// cmvc_ctrl
// Controller: sequences item intake, per-node division and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmvc_ctrl import cmvc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAC  = 4'd1;
  localparam logic [3:0] S_DCHK = 4'd2;
  localparam logic [3:0] S_DIT  = 4'd3;
  localparam logic [3:0] S_DFIN = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic [1:0] COMP_LAST = 2'd2;
  localparam logic [4:0] BIT_TOP   = 5'(DATA_W - 1);

  logic [3:0] state_q, state_d;
  logic [1:0] comp_q, comp_d;
  logic [4:0] bit_q, bit_d;

  // Next state
  always_comb begin
    state_d = state_q;
    comp_d  = comp_q;
    bit_d   = bit_q;
    unique case (state_q)
      S_IDLE: begin
        comp_d = '0;
        if (sts_i.in_valid) begin
          priority if (!sts_i.full) begin
            state_d = S_MAC;
          end else if (sts_i.in_last) begin
            state_d = S_DCHK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_MAC: begin
        if (comp_q == COMP_LAST) begin
          comp_d  = '0;
          state_d = sts_i.last ? S_DCHK : S_IDLE;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      S_DCHK: begin
        priority if (sts_i.zm) begin
          comp_d  = '0;
          state_d = S_RD;
        end else if (sts_i.sat) begin
          if (comp_q == COMP_LAST) begin
            comp_d  = '0;
            state_d = S_RD;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          bit_d   = BIT_TOP;
          state_d = S_DIT;
        end
      end
      S_DIT: begin
        if (bit_q == '0) begin
          state_d = S_DFIN;
        end else begin
          bit_d = bit_q - 5'd1;
        end
      end
      S_DFIN: begin
        if (comp_q == COMP_LAST) begin
          comp_d  = '0;
          state_d = S_RD;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_DCHK;
        end
      end
      S_RD: begin
        comp_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ADD;
      end
      S_ADD: begin
        if (comp_q == COMP_LAST) begin
          state_d = S_OUT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.k_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
      bit_q   <= bit_d;
    end
  end

  // Commands
  assign cmd_o.in_ready = (state_q == S_IDLE);
  assign cmd_o.mac      = (state_q == S_MAC);
  assign cmd_o.div_chk  = (state_q == S_DCHK);
  assign cmd_o.div_step = (state_q == S_DIT);
  assign cmd_o.div_fin  = (state_q == S_DFIN);
  assign cmd_o.mul      = (state_q == S_MUL);
  assign cmd_o.add      = (state_q == S_ADD);
  assign cmd_o.out_load = (state_q == S_OUT) && sts_i.out_free;
  assign cmd_o.k_inc    = cmd_o.out_load && !sts_i.k_last;
  assign cmd_o.clr      = cmd_o.out_load && sts_i.k_last;
  assign cmd_o.comp     = comp_q;

  // Checks
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q != 2'd3) else $error("component index out of range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIT) |-> !sts_i.zm) else $error("divide by zero mass");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIT && bit_q == '0) |=> (state_q == S_DFIN))
    else $error("divider did not finish");

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free) else $error("output register overrun");

endmodule

### hdl/center_of_mass_velocity_contact.sv
// ----------------------------------------------------------------------------
// center_of_mass_velocity_contact
// Center-of-mass velocity and acceleration correction for one grid node.
// ----------------------------------------------------------------------------
// Each accepted material item is transferred and then gets one momentum
// multiply-accumulate per axis through a single multiplier; an item beyond
// the buffer capacity is accepted but neither buffered nor summed. The item
// marked last closes the node: a bit-serial divider then makes a single check
// for a zero total mass, otherwise per axis a check for a saturating quotient
// or a full division, followed for each buffered material by a buffer read,
// then a multiply and an add per axis, before each result is loaded into the
// output register once it is free. Results appear in arrival order.
`timescale 1ns / 1ps

module center_of_mass_velocity_contact import cmvc_pkg::*; #(
  parameter int unsigned MAX_MATERIALS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  cmvc_item_if.sink     item_i,
  cmvc_result_if.source result_o,
  cmvc_cfg_if.sink      cfg_i
);

  cmd_t cmd;
  sts_t sts;

  cmvc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cmvc_dp #(.MAX_MATERIALS(MAX_MATERIALS)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .result_o (result_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

endmodule
